// ===== src/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants for the aging sighting table
// field widths, opcodes, controller states and the control/status bundles
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int ENTRIES_DEFAULT = 16;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int STR_W  = 16;
  localparam int MAR_W  = 8;
  localparam int AGE_W  = 16;

  // stored entry word: id, strength, margin, time from the lowest bit up
  localparam int WORD_W = ID_W + STR_W + MAR_W + TIME_W;

  localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd30000;

  // age to tenths: ages at or above 65536 * 100 ms saturate
  localparam int TENTH_MS = 100;
  localparam logic [TIME_W-1:0] AGE_SAT_MS = TIME_W'((2 ** AGE_W) * TENTH_MS);
  // below the saturation point the age fits in 23 bits and
  // floor(x * ceil(2^30 / 100) / 2^30) equals x / 100 exactly
  localparam int DIV_IN_W    = 23;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int PROD_W      = DIV_IN_W + RECIP_W;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_SCAN,
    S_REC_LAST,
    S_REC_WRITE,
    S_PURGE_SCAN,
    S_PURGE_LAST,
    S_EMIT_SEL,
    S_EMIT_AGE,
    S_EMIT_DIV,
    S_EMIT_OUT,
    S_EMIT_EMPTY
  } state_t;

  typedef struct packed {
    logic in_load;
    logic scan_start;
    logic idx_clr;
    logic idx_inc;
    logic rec_read;
    logic purge_read;
    logic rec_write;
    logic emit_read;
    logic age_load;
    logic div_load;
    logic out_load;
    logic out_empty;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic cur_valid;
    logic live_zero;
    logic live_one;
    logic out_free;
  } status_t;

endpackage

// ===== src/ast_ram.sv =====
// ----------------------------------------------------------------------------
// ast_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ast_ctrl.sv =====
// ----------------------------------------------------------------------------
// ast_ctrl: sequencer for the aging sighting table
// runs the record scan, the purge scan and the per-entry report steps
// ----------------------------------------------------------------------------
module ast_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  input  ast_pkg::status_t status,
  output ast_pkg::cmd_t    cmd
);

  import ast_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load    = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_next     = (op_t'(in_op) == OP_REPORT) ? S_PURGE_SCAN : S_REC_SCAN;
        end
      end
      S_REC_SCAN: begin
        cmd.rec_read = 1'b1;
        if (status.idx_last) begin
          state_next = S_REC_LAST;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_REC_LAST: begin
        state_next = S_REC_WRITE;
      end
      S_REC_WRITE: begin
        cmd.rec_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_PURGE_SCAN: begin
        cmd.purge_read = 1'b1;
        if (status.idx_last) begin
          state_next = S_PURGE_LAST;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PURGE_LAST: begin
        cmd.idx_clr = 1'b1;
        state_next  = S_EMIT_SEL;
      end
      S_EMIT_SEL: begin
        if (status.live_zero) begin
          state_next = S_EMIT_EMPTY;
        end else if (status.cur_valid) begin
          cmd.emit_read = 1'b1;
          state_next    = S_EMIT_AGE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT_AGE: begin
        cmd.age_load = 1'b1;
        state_next   = S_EMIT_DIV;
      end
      S_EMIT_DIV: begin
        cmd.div_load = 1'b1;
        state_next   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.live_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_EMIT_SEL;
          end
        end
      end
      S_EMIT_EMPTY: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ast_dp.sv =====
// ----------------------------------------------------------------------------
// ast_dp: datapath of the aging sighting table
// entry ram, valid bits, scan trackers, age divider and output register
// ----------------------------------------------------------------------------
module ast_dp #(
  parameter int ENTRIES = ast_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ast_pkg::cmd_t                cmd,
  output ast_pkg::status_t             status,
  input  logic                         cfg_we,
  input  logic [ast_pkg::TIME_W-1:0]   cfg_wdata,
  input  logic [ast_pkg::TIME_W-1:0]   in_now,
  input  logic [ast_pkg::ID_W-1:0]     in_id,
  input  logic signed [ast_pkg::STR_W-1:0] in_strength,
  input  logic signed [ast_pkg::MAR_W-1:0] in_margin,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_entry_valid,
  output logic [ast_pkg::ID_W-1:0]     out_id,
  output logic signed [ast_pkg::STR_W-1:0] out_strength,
  output logic signed [ast_pkg::MAR_W-1:0] out_margin,
  output logic [ast_pkg::AGE_W-1:0]    out_age,
  output logic                         out_last
);

  import ast_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // captured item and limit register
  logic [TIME_W-1:0]       now_r;
  logic [ID_W-1:0]         id_r;
  logic signed [STR_W-1:0] strength_r;
  logic signed [MAR_W-1:0] margin_r;
  logic [TIME_W-1:0]       stale_limit;

  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   look_idx;
  logic               look_rec;
  logic               look_purge;

  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               empty_found;
  logic [IDX_W-1:0]   empty_idx;
  logic               oldest_found;
  logic [IDX_W-1:0]   evict_idx;
  logic [TIME_W-1:0]  oldest_time;
  logic [CNT_W-1:0]   live_cnt;

  logic [TIME_W-1:0]  age_r;
  logic               sat_r;
  logic [PROD_W-1:0]  prod_r;

  // ram port signals
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [WORD_W-1:0]  wr_word;
  logic               rd_en;
  logic [WORD_W-1:0]  rd_word;

  logic [ID_W-1:0]         rd_id;
  logic signed [STR_W-1:0] rd_strength;
  logic signed [MAR_W-1:0] rd_margin;
  logic [TIME_W-1:0]       rd_time;
  logic [TIME_W-1:0]       scan_age;
  logic                    look_valid;
  logic                    out_free;

  assign rd_id       = rd_word[ID_W-1:0];
  assign rd_strength = rd_word[ID_W +: STR_W];
  assign rd_margin   = rd_word[ID_W+STR_W +: MAR_W];
  assign rd_time     = rd_word[ID_W+STR_W+MAR_W +: TIME_W];

  assign look_valid = valid[look_idx];
  assign scan_age   = now_r - rd_time;

  // write target: matching entry, else first empty, else oldest
  always_comb begin
    if (match_found) begin
      wr_idx = match_idx;
    end else if (empty_found) begin
      wr_idx = empty_idx;
    end else begin
      wr_idx = evict_idx;
    end
  end

  assign wr_en   = cmd.rec_write && (id_r != '0);
  assign wr_word = {now_r, margin_r, strength_r, id_r};
  assign rd_en   = cmd.rec_read || cmd.purge_read || cmd.emit_read;

  ast_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      stale_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      now_r      <= in_now;
      id_r       <= in_id;
      strength_r <= in_strength;
      margin_r   <= in_margin;
    end
  end

  // scan index and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      look_rec   <= 1'b0;
      look_purge <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      look_rec   <= cmd.rec_read;
      look_purge <= cmd.purge_read;
    end
  end

  always_ff @(posedge clk) begin
    look_idx <= idx;
  end

  // valid bits: set by a record write, cleared by the purge
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end else if (look_purge && look_valid && (scan_age > stale_limit)) begin
      valid[look_idx] <= 1'b0;
    end
  end

  // scan trackers and live count
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found  <= 1'b0;
      empty_found  <= 1'b0;
      oldest_found <= 1'b0;
      live_cnt     <= '0;
    end else if (cmd.scan_start) begin
      match_found  <= 1'b0;
      empty_found  <= 1'b0;
      oldest_found <= 1'b0;
      live_cnt     <= '0;
    end else begin
      if (look_rec) begin
        if (look_valid && !match_found && (rd_id == id_r)) begin
          match_found <= 1'b1;
        end
        if (!look_valid && !empty_found) begin
          empty_found <= 1'b1;
        end
        if (look_valid && (!oldest_found || (rd_time < oldest_time))) begin
          oldest_found <= 1'b1;
        end
      end
      if (look_purge && look_valid && !(scan_age > stale_limit)) begin
        live_cnt <= live_cnt + 1'b1;
      end else if (cmd.out_load && !cmd.out_empty) begin
        live_cnt <= live_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_rec) begin
      if (look_valid && !match_found && (rd_id == id_r)) begin
        match_idx <= look_idx;
      end
      if (!look_valid && !empty_found) begin
        empty_idx <= look_idx;
      end
      if (look_valid && (!oldest_found || (rd_time < oldest_time))) begin
        evict_idx   <= look_idx;
        oldest_time <= rd_time;
      end
    end
  end

  // age then reciprocal multiply, one register after each
  always_ff @(posedge clk) begin
    if (cmd.age_load) begin
      age_r <= scan_age;
    end
    if (cmd.div_load) begin
      sat_r  <= (age_r >= AGE_SAT_MS);
      prod_r <= PROD_W'(age_r[DIV_IN_W-1:0]) * PROD_W'(RECIP);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_entry_valid <= 1'b0;
        out_id          <= '0;
        out_strength    <= '0;
        out_margin      <= '0;
        out_age         <= '0;
        out_last        <= 1'b1;
      end else begin
        out_entry_valid <= 1'b1;
        out_id          <= rd_id;
        out_strength    <= rd_strength;
        out_margin      <= rd_margin;
        out_age         <= sat_r ? '1 : prod_r[RECIP_SHIFT +: AGE_W];
        out_last        <= (live_cnt == CNT_W'(1));
      end
    end
  end

  assign status.idx_last  = (idx == IDX_LAST);
  assign status.cur_valid = valid[idx];
  assign status.live_zero = (live_cnt == '0);
  assign status.live_one  = (live_cnt == CNT_W'(1));
  assign status.out_free  = out_free;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over a waiting result");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_read |-> valid[idx])
    else $error("report read of an empty entry");

  a_live_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !cmd.out_empty) |-> (live_cnt != '0))
    else $error("entry result with no live entry left");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_cnt <= CNT_W'(ENTRIES))
    else $error("live count beyond table size");

endmodule

// ===== src/aging_sighting_table_unit.sv =====
// ----------------------------------------------------------------------------
// aging_sighting_table_unit: table of recently heard device ids
// records sightings into an aging table and reports its live entries
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (low bit up)                           tuser        tlast
// s_axis    in   now_ms, heard_id, signal_strength,           opcode       -
//                noise_margin (88 bits)
// m_axis    out  out_heard_id, out_strength, out_margin,      entry_valid  last
//                age_tenths (72 bits)
// cfg       in   cfg_wdata = stale_limit_ms, written when cfg_we is high
//
// a record word reads every entry in turn, one ram read per entry, set by the
//   single read port of the entry ram, then writes the chosen entry
// a report word first runs a purge scan over every entry, then per live entry
//   the read, age, multiply and output load steps, plus a skip per empty slot
// the output register lets the last result wait while the next word is taken
// rst is synchronous; it empties the table and sets the stale limit to 30000
// a stalled m_axis holds the controller in its output step
//
module aging_sighting_table_unit #(
  parameter int ENTRIES = ast_pkg::ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // now_ms, heard_id, signal_strength, noise_margin
  input  logic [0:0]  s_axis_tuser,   // opcode
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_heard_id, out_strength, out_margin, age_tenths
  output logic [0:0]  m_axis_tuser,   // entry_valid
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata       // stale_limit_ms
);

  import ast_pkg::*;

  cmd_t    cmd;
  status_t status;

  // unpacked input fields
  logic [TIME_W-1:0]       in_now;
  logic [ID_W-1:0]         in_id;
  logic signed [STR_W-1:0] in_strength;
  logic signed [MAR_W-1:0] in_margin;

  // result fields
  logic                    res_entry_valid;
  logic [ID_W-1:0]         res_id;
  logic signed [STR_W-1:0] res_strength;
  logic signed [MAR_W-1:0] res_margin;
  logic [AGE_W-1:0]        res_age;

  assign in_now      = s_axis_tdata[31:0];
  assign in_id       = s_axis_tdata[63:32];
  assign in_strength = s_axis_tdata[79:64];
  assign in_margin   = s_axis_tdata[87:80];

  // controller accepts a word only when idle
  ast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ast_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_now          (in_now),
    .in_id           (in_id),
    .in_strength     (in_strength),
    .in_margin       (in_margin),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_entry_valid (res_entry_valid),
    .out_id          (res_id),
    .out_strength    (res_strength),
    .out_margin      (res_margin),
    .out_age         (res_age),
    .out_last        (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {res_age, res_margin, res_strength, res_id};
  assign m_axis_tuser = res_entry_valid;

endmodule

// ===== tb/tb_aging_sighting_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_aging_sighting_table_unit: self-checking bench for the sighting table
// feeds record and report words over s_axis, keeps a shadow copy of the
// table and compares every m_axis word, field by field, with the rows that
// the shadow table says a report must produce
// ----------------------------------------------------------------------------
module tb_aging_sighting_table_unit;
  import ast_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEFAULT;
  localparam int AGE_MAX     = 2 ** AGE_W - 1;
  localparam int ID_POOL     = 20;
  localparam int SETTLE_CYC  = 200;   // covers a full report plus a record
  localparam int HOLD_CYC    = 300;   // long m_axis hold-off
  localparam int QUIET_LIMIT = 5000;  // cycles with no handshake at all

  typedef struct {
    op_t                     op;
    logic [TIME_W-1:0]       now;
    logic [ID_W-1:0]         id;
    logic signed [STR_W-1:0] str;
    logic signed [MAR_W-1:0] mar;
  } sighting_word_t;

  typedef struct {
    logic                    live;
    logic [ID_W-1:0]         id;
    logic signed [STR_W-1:0] str;
    logic signed [MAR_W-1:0] mar;
    logic [AGE_W-1:0]        age;
    logic                    last;
  } table_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;   // now_ms, heard_id, signal_strength, noise_margin
  logic [0:0]  s_axis_tuser = '0;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // out_heard_id, out_strength, out_margin, age_tenths
  logic [0:0]  m_axis_tuser;        // entry_valid
  logic        m_axis_tlast;        // last
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;      // stale_limit_ms

  aging_sighting_table_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow table and stale limit, as the block should hold them
  logic [ID_W-1:0]   ent_id   [ENTRIES];
  logic [STR_W-1:0]  ent_str  [ENTRIES];
  logic [MAR_W-1:0]  ent_mar  [ENTRIES];
  logic [TIME_W-1:0] ent_time [ENTRIES];
  logic [TIME_W-1:0] purge_limit = LIMIT_RESET;

  sighting_word_t word_q[$];     // words waiting for the driver
  table_row_t     rows_due[$];   // report rows not yet seen on m_axis
  int             words_offered = 0;
  int             words_taken   = 0;
  int             bad_count     = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_asked = 0;
  logic [TIME_W-1:0] wall_ms = '0;
  logic [ID_W-1:0]   id_pool [ID_POOL];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow table

  function automatic void table_record(logic [TIME_W-1:0] now, logic [ID_W-1:0] id,
                                       logic [STR_W-1:0] str, logic [MAR_W-1:0] mar);
    int slot;
    slot = -1;
    if (id == '0)
      return;
    // same id first, then the lowest empty slot, then the oldest stamp
    for (int k = 0; k < ENTRIES; k++)
      if (slot < 0 && ent_id[k] == id) slot = k;
    for (int k = 0; k < ENTRIES; k++)
      if (slot < 0 && ent_id[k] == '0) slot = k;
    if (slot < 0) begin
      slot = 0;
      // plain unsigned compare, strict so ties keep the lowest index
      for (int k = 1; k < ENTRIES; k++)
        if (ent_time[k] < ent_time[slot]) slot = k;
    end
    ent_id[slot]   = id;
    ent_str[slot]  = str;
    ent_mar[slot]  = mar;
    ent_time[slot] = now;
  endfunction

  function automatic void table_report(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] tenths;
    table_row_t row;
    int n;
    n = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      age = now - ent_time[k];
      if (ent_id[k] != '0 && age > purge_limit) ent_id[k] = '0;
    end
    for (int k = 0; k < ENTRIES; k++) begin
      if (ent_id[k] != '0) begin
        age = now - ent_time[k];
        tenths = age / TENTH_MS;
        if (tenths > TIME_W'(AGE_MAX)) tenths = TIME_W'(AGE_MAX);
        row.live = 1'b1;
        row.id   = ent_id[k];
        row.str  = ent_str[k];
        row.mar  = ent_mar[k];
        row.age  = tenths[AGE_W-1:0];
        row.last = 1'b0;
        rows_due.push_back(row);
        n++;
      end
    end
    if (n == 0) begin
      // empty table: one invalid word with last set
      row = '{live: 1'b0, id: '0, str: '0, mar: '0, age: '0, last: 1'b1};
      rows_due.push_back(row);
    end else begin
      rows_due[rows_due.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void push_record(logic [TIME_W-1:0] now, logic [ID_W-1:0] id,
                                      logic [STR_W-1:0] str, logic [MAR_W-1:0] mar);
    sighting_word_t w;
    w.op  = OP_RECORD;
    w.now = now;
    w.id  = id;
    w.str = str;
    w.mar = mar;
    word_q.push_back(w);
  endfunction

  function automatic void push_report(logic [TIME_W-1:0] now);
    sighting_word_t w;
    w.op  = OP_REPORT;
    w.now = now;
    w.id  = ID_W'($urandom);   // ignored by a report, but toggled anyway
    w.str = STR_W'($urandom);
    w.mar = MAR_W'($urandom);
    word_q.push_back(w);
  endfunction

  // wait until every word is in and every row is out, then let the block go idle
  task automatic settle();
    while (word_q.size() != 0 || words_offered != words_taken || rows_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly a wall clock moving forward with a pool of recurring ids,
  // with some stray ids, zero ids, long silences and out-of-order reports
  task automatic random_traffic(int n);
    int jump;
    int pick;
    logic [ID_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      jump = $urandom_range(99);
      if (jump < 80)      wall_ms += $urandom_range(1, 600);
      else if (jump < 95) wall_ms += $urandom_range(600, 8000);
      else                wall_ms += $urandom;
      pick = $urandom_range(99);
      if (pick < 20) begin
        if ($urandom_range(19) == 0) push_report($urandom);
        else                         push_report(wall_ms);
      end else begin
        if (pick < 65)      id = id_pool[$urandom_range(ID_POOL - 1)];
        else if (pick < 88) id = $urandom;
        else if (pick < 94) id = '0;
        else                id = '1;
        push_record(wall_ms, id, STR_W'($urandom), MAR_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : driver
    sighting_word_t w;
    // a word on the bus stays put until taken
    if (!rst && words_offered == words_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_q.pop_front();
        s_axis_tdata  <= {w.mar, w.str, w.id, w.now};
        s_axis_tuser  <= w.op;
        s_axis_tvalid <= 1'b1;
        words_offered++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  int hold_left = 0;
  int hold_done = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_bad(string what, table_row_t want, table_row_t got);
    bad_count++;
    if (bad_count <= 10)
      $display("mismatch, %s: expected live=%0b id=%h str=%0d mar=%0d age=%0d last=%0b,",
               what, want.live, want.id, want.str, want.mar, want.age, want.last,
               " got live=%0b id=%h str=%0d mar=%0d age=%0d last=%0b",
               got.live, got.id, got.str, got.mar, got.age, got.last);
  endtask

  always @(posedge clk) begin : monitor
    table_row_t got;
    table_row_t want;
    if (!rst) begin
      if (cfg_we) purge_limit = cfg_wdata;
      // output first: a word leaving now belongs to an earlier report
      if (m_axis_tvalid && m_axis_tready) begin
        got.live = m_axis_tuser[0];
        got.id   = m_axis_tdata[31:0];
        got.str  = m_axis_tdata[47:32];
        got.mar  = m_axis_tdata[55:48];
        got.age  = m_axis_tdata[71:56];
        got.last = m_axis_tlast;
        if (rows_due.size() == 0) begin
          want = '{live: 1'b0, id: '0, str: '0, mar: '0, age: '0, last: 1'b0};
          note_bad("word with no row due", want, got);
        end else begin
          want = rows_due.pop_front();
          if (got.live !== want.live || got.id !== want.id || got.str !== want.str ||
              got.mar !== want.mar || got.age !== want.age || got.last !== want.last)
            note_bad("report row", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_taken++;
        if (op_t'(s_axis_tuser[0]) == OP_REPORT)
          table_report(s_axis_tdata[31:0]);
        else
          table_record(s_axis_tdata[31:0], s_axis_tdata[63:32],
                       s_axis_tdata[79:64], s_axis_tdata[87:80]);
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[aging_sighting_table_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stimulus
    logic [TIME_W-1:0] stamp;
    logic [ID_W-1:0]   fill_id;
    logic [STR_W-1:0]  fill_str;
    logic [MAR_W-1:0]  fill_mar;
    for (int k = 0; k < ENTRIES; k++) begin
      ent_id[k]   = '0;
      ent_str[k]  = '0;
      ent_mar[k]  = '0;
      ent_time[k] = '0;
    end
    for (int i = 0; i < ID_POOL; i++)
      id_pool[i] = $urandom | 32'h1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stale boundary at the reset limit: age equal to the limit stays,
    // one more ms purges it and the report comes back empty
    push_record(100, 32'h0000_00A5, -16'sd40, 8'sd12);
    push_report(30100);
    push_report(30101);
    settle();

    // zero limit: only an entry heard this very ms survives
    write_limit('0);
    push_record(0, 32'hC0FF_EE01, -16'sd90, 8'sd3);
    push_report(0);
    settle();

    // nothing goes stale; fill the table, update, evict, report all 16
    write_limit('1);
    push_record(123, '0, 16'sh7FFF, 8'sh7F);   // id zero does nothing
    for (int i = 1; i < ENTRIES; i++) begin
      case (i)
        5:       stamp = '0;              // ties with slot 0 for oldest
        6:       stamp = '1;              // biggest stamp, wrapped age later
        11:      stamp = 32'hFF00_0000;   // age saturates at the report
        default: stamp = 1000 + i;
      endcase
      fill_id  = (i == 1) ? '1 : 32'h5160_0000 + i;
      case (i % 3)
        0:       begin fill_str = 16'sh8000; fill_mar = 8'sh80; end
        1:       begin fill_str = 16'sh7FFF; fill_mar = 8'sh7F; end
        default: begin fill_str = STR_W'($urandom); fill_mar = MAR_W'($urandom); end
      endcase
      push_record(stamp, fill_id, fill_str, fill_mar);
    end
    push_record(5000, 32'h5160_0002, -16'sd1, -8'sd1);   // same id, refreshed
    push_record(5001, 32'h0BAD_CAFE, 16'sd0, 8'sd0);     // full: evicts slot 0
    push_report(6000);
    settle();
    wall_ms = 6000;

    // random traffic under four idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_limit(LIMIT_RESET); end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;
                 write_limit($urandom_range(100, 20000)); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; write_limit($urandom); end
        default: begin send_idle_pct = 15; recv_stall_pct = 15;
                 write_limit($urandom_range(1000, 100000)); end
      endcase
      if (ph == 0) hold_asked++;   // back-pressure until the input stalls
      if (ph == 3) begin
        random_traffic(10);
        settle();                  // sender waits for every row to drain
        random_traffic(10);
      end else begin
        random_traffic(22);
      end
      settle();
    end

    if (bad_count == 0 && rows_due.size() == 0)
      $display("[aging_sighting_table_unit] OK");
    else
      $display("[aging_sighting_table_unit] ERROR");
    $finish;
  end

endmodule
